// ===== rtl/core/mt19937_random_generator_top_assert.svh =====
// Assertion macros used by the checker file of the generator.
`ifndef MT19937_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_TOP_ASSERT_SVH

// Next-cycle implication, quiet while reset is asserted.
`define MTRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtrg: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define MTRG_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mtrg: reset check failed");

`endif

// ===== rtl/core/mtrg_pkg.sv =====
package mtrg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned OUT_W        = 31;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [31:0]      word_t;

  localparam word_t SEED_DEFAULT = 32'd4357;
  localparam word_t SEED_MULT    = 32'd69069;
  localparam word_t TWIST_XOR    = 32'h9908_b0df;
  localparam word_t HIGH_BIT     = 32'h8000_0000;
  localparam word_t LOW_BITS     = 32'h7fff_ffff;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;

  localparam idx_t LAST_IDX   = idx_t'(STATE_WORDS - 1);
  localparam idx_t FAR_OFFSET = idx_t'(TWIST_OFFSET);
  localparam idx_t NEXT_STEP  = idx_t'(1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_CALC = 3'b100
  } state_t;

  // Add an offset to a store index, wrapping at the store depth.
  function automatic idx_t idx_wrap_add(idx_t base, idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(STATE_WORDS)) begin
      sum = sum - (IDX_W+1)'(STATE_WORDS);
    end
    return sum[IDX_W-1:0];
  endfunction

  // One recurrence step: high bit of this word, low bits of the next one.
  function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
    word_t y;
    word_t v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_XOR;
    end
    return v;
  endfunction

  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== rtl/core/mtrg_ifs.sv =====
interface mtrg_draw_if ();
  logic valid;
  logic ready;
  logic draw;

  modport source (output valid, output draw, input ready);
  modport sink   (input valid, input draw, output ready);
endinterface

interface mtrg_rand_if import mtrg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

interface mtrg_seed_if import mtrg_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t seed_value;

  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

// ===== rtl/core/mt19937_random_generator_top.sv =====
// Channel  Dir  Payload                 Handshake
// cfg_if   in   seed_value  [31:0]      valid/ready, ready always high
// in_if    in   draw        [0]         valid/ready, item taken on both high
// out_if   out  random_value[30:0]      valid/ready, item taken on both high
//
// A draw item is worked in order: accept (store read issued), then twist,
// write-back and temper into the output register. No new draw is taken
// before that; the two-read store port and the twisted-word write-back set the pace.
// The first draw after reset or a seed write first fills all 624 store words.
// Reset clears control state and loads seed 4357; the store fills on demand.
// A stalled output holds the finished word; the next draw waits in the
// twist stage until the output register frees. Items with draw low are dropped.
module mt19937_random_generator_top import mtrg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  mtrg_seed_if.sink          cfg_if,
  mtrg_draw_if.sink          in_if,
  mtrg_rand_if.source        out_if
);

  // State store: one write port, two registered read ports.
  word_t store_mem [STATE_WORDS];

  state_t           state_r,      state_nxt;
  word_t            seed_r,       seed_nxt;
  logic             reseed_r,     reseed_nxt;
  idx_t             idx_r,        idx_nxt;
  word_t            cur_r,        cur_nxt;
  idx_t             fill_cnt_r,   fill_cnt_nxt;
  word_t            fill_word_r,  fill_word_nxt;
  logic             out_valid_r,  out_valid_nxt;
  logic [OUT_W-1:0] out_data_r,   out_data_nxt;
  word_t            rd_a_r;
  word_t            rd_b_r;

  logic  rd_en;
  idx_t  rd_base;
  idx_t  rd_addr_a;
  idx_t  rd_addr_b;
  logic  wr_en;
  idx_t  wr_addr;
  word_t wr_data;
  word_t new_word;
  word_t tempered;

  assign in_if.ready         = (state_r == ST_IDLE);
  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.random_value = out_data_r;

  // The word at the read index is cached in cur_r, so only the next word
  // and the far word come from the store.
  assign new_word  = twist_word(cur_r, rd_a_r, rd_b_r);
  assign tempered  = temper(new_word);
  assign rd_base   = (state_r == ST_FILL) ? '0 : idx_r;
  assign rd_addr_a = idx_wrap_add(rd_base, NEXT_STEP);
  assign rd_addr_b = idx_wrap_add(rd_base, FAR_OFFSET);

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    reseed_nxt    = reseed_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_word_nxt = fill_word_r;
    out_valid_nxt = out_valid_r & ~out_if.ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = new_word;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid && in_if.draw) begin
          if (reseed_r) begin
            // Start a refill; word 0 is the seed itself.
            state_nxt     = ST_FILL;
            fill_cnt_nxt  = '0;
            fill_word_nxt = seed_r;
            cur_nxt       = seed_r;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      ST_FILL: begin
        // Write one seeded word per cycle, advance the multiplicative congruential chain.
        wr_en         = 1'b1;
        wr_addr       = fill_cnt_r;
        wr_data       = fill_word_r;
        fill_word_nxt = fill_word_r * SEED_MULT;
        fill_cnt_nxt  = fill_cnt_r + NEXT_STEP;
        if (fill_cnt_r == LAST_IDX) begin
          // Store full: fetch words 1 and 397 for the pending draw.
          reseed_nxt = 1'b0;
          idx_nxt    = '0;
          rd_en      = 1'b1;
          state_nxt  = ST_CALC;
        end
      end
      ST_CALC: begin
        // Hold while the previous result still waits to be taken.
        if (!out_valid_r || out_if.ready) begin
          wr_en         = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = tempered[OUT_W-1:0];
          cur_nxt       = rd_a_r;
          idx_nxt       = (idx_r == LAST_IDX) ? '0 : idx_r + NEXT_STEP;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A seed write arms a refill on the next draw.
    if (cfg_if.valid) begin
      seed_nxt   = cfg_if.seed_value;
      reseed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= SEED_DEFAULT;
      reseed_r    <= 1'b1;
      idx_r       <= '0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      reseed_r    <= reseed_nxt;
      idx_r       <= idx_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    fill_word_r <= fill_word_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads, so a stalled twist stage keeps its operands.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= store_mem[rd_addr_a];
      rd_b_r <= store_mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/core/mtrg_checker.sv =====
`include "mt19937_random_generator_top_assert.svh"

module mtrg_checker import mtrg_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_draw,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_random_value
);

  // Reset empties the output.
  `MTRG_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)

  // A draw item blocks the input while it is worked on.
  `MTRG_ASSERT_NEXT(a_draw_blocks_input, clk, rst_n,
    in_valid && in_ready && in_draw, !in_ready)

  // An empty request leaves the input open.
  `MTRG_ASSERT_NEXT(a_drop_keeps_ready, clk, rst_n,
    in_valid && in_ready && !in_draw, in_ready)

  // A waiting result holds.
  `MTRG_ASSERT_NEXT(a_out_holds, clk, rst_n,
    out_valid && !out_ready, out_valid && $stable(out_random_value))

endmodule

bind mt19937_random_generator_top mtrg_checker u_mtrg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_draw          (in_if.draw),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_random_value (out_if.random_value)
);

// ===== dv/mtrg_stream_checker.sv =====
module mtrg_stream_checker import mtrg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mtrg_seed_if        seed_ch,
  mtrg_draw_if        draw_ch,
  mtrg_rand_if        rand_ch,
  output int unsigned fail_count,
  output int unsigned results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  word_t            mt_store [STATE_WORDS];
  int unsigned      read_pos;
  bit               refill_armed;
  word_t            seed_reg;
  logic [OUT_W-1:0] expected_words [$];
  int unsigned      mismatches;
  logic [OUT_W-1:0] want;

  // Advance the generator by one word and return it tempered, top bit dropped.
  function automatic logic [OUT_W-1:0] next_tempered();
    word_t       y;
    word_t       mix;
    int unsigned k;
    if (refill_armed) begin
      mt_store[0] = seed_reg;
      for (k = 1; k < STATE_WORDS; k++) begin
        mt_store[k] = mt_store[k-1] * SEED_MULT;
      end
      read_pos     = STATE_WORDS;
      refill_armed = 1'b0;
    end
    if (read_pos >= STATE_WORDS) begin
      // in place: later words see the already twisted ones
      for (k = 0; k < STATE_WORDS; k++) begin
        mix = (mt_store[k] & HIGH_BIT) | (mt_store[(k + 1) % STATE_WORDS] & LOW_BITS);
        y   = mt_store[(k + TWIST_OFFSET) % STATE_WORDS] ^ (mix >> 1);
        if (mix[0]) begin
          y = y ^ TWIST_XOR;
        end
        mt_store[k] = y;
      end
      read_pos = 0;
    end
    y = mt_store[read_pos];
    read_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      read_pos     = STATE_WORDS;
      refill_armed = 1'b1;
      seed_reg     = SEED_DEFAULT;
      mismatches   = 0;
      expected_words.delete();
    end else begin
      if (seed_ch.valid && seed_ch.ready) begin
        seed_reg     = seed_ch.seed_value;
        refill_armed = 1'b1;
      end
      if (rand_ch.valid && rand_ch.ready) begin
        if (expected_words.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("unexpected random_value %h", rand_ch.random_value);
          end
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (rand_ch.random_value !== want) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("random_value mismatch: expected %h, got %h", want,
                       rand_ch.random_value);
            end
            mismatches++;
          end
        end
      end
      // a draw of zero is dropped by the block and leaves the state alone
      if (draw_ch.valid && draw_ch.ready && draw_ch.draw) begin
        expected_words.push_back(next_tempered());
      end
    end
    fail_count   <= mismatches;
    results_owed <= expected_words.size();
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  import mtrg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Draw requests: a one asks for a number, a zero is dropped by the block.
  localparam bit DRAW_REQ  = 1'b1;
  localparam bit DRAW_NONE = 1'b0;

  localparam int unsigned RANDOM_DRAWS = 1550;
  localparam int unsigned FIRST_RUN    = 720;   // crosses one full twist
  localparam int unsigned SETTLE       = 4;     // idle wait after drain before a seed write
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  logic clk;
  logic rst_n;

  mtrg_seed_if seed_ch ();
  mtrg_draw_if draw_ch ();
  mtrg_rand_if rand_ch ();

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned cycle_count;

  // When set, both sides run back to back with no random gaps or stalls.
  bit quiet;

  mt19937_random_generator_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (seed_ch),
    .in_if  (draw_ch),
    .out_if (rand_ch)
  );

  mtrg_stream_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .seed_ch      (seed_ch),
    .draw_ch      (draw_ch),
    .rand_ch      (rand_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Hand one draw item to the block after a random gap. Valid stays high on
  // return so that a zero gap on the next item gives back-to-back transfers.
  task automatic send_draw(input bit req);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      draw_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    draw_ch.valid <= 1'b1;
    draw_ch.draw  <= req;
    do @(posedge clk); while (!draw_ch.ready);
  endtask

  // Hold off draws until every predicted number has come back.
  task automatic drain();
    draw_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Write the seed only with the block idle; the refill then runs on the next draw.
  task automatic load_seed(input word_t seed);
    drain();
    repeat (SETTLE) @(posedge clk);
    seed_ch.valid      <= 1'b1;
    seed_ch.seed_value <= seed;
    do @(posedge clk); while (!seed_ch.ready);
    seed_ch.valid <= 1'b0;
  endtask

  // Result side: stall a random number of cycles before each item.
  initial begin
    int unsigned stall;
    rand_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        rand_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rand_ch.ready <= 1'b1;
      do @(posedge clk); while (!rand_ch.valid);
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned drawn;
    int unsigned run_len;
    int unsigned phase;
    int unsigned i;
    word_t       seed;

    quiet              = 1'b0;
    rst_n              <= 1'b0;
    draw_ch.valid      <= 1'b0;
    draw_ch.draw       <= DRAW_NONE;
    seed_ch.valid      <= 1'b0;
    seed_ch.seed_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default seed straight out of reset, with a dropped request in between.
    send_draw(DRAW_REQ);
    send_draw(DRAW_REQ);
    send_draw(DRAW_NONE);
    send_draw(DRAW_REQ);
    send_draw(DRAW_REQ);

    // Zero seed: the store fills with zeros and every number is zero.
    load_seed('0);
    send_draw(DRAW_REQ);
    send_draw(DRAW_REQ);
    send_draw(DRAW_REQ);

    // All-ones seed, then two writes in a row where only the last one counts.
    load_seed('1);
    send_draw(DRAW_REQ);
    send_draw(DRAW_NONE);
    send_draw(DRAW_REQ);
    load_seed(32'h0000_0001);
    load_seed(32'h7fff_ffff);
    quiet = 1'b1;
    send_draw(DRAW_REQ);
    send_draw(DRAW_REQ);
    send_draw(DRAW_REQ);
    quiet = 1'b0;

    // Top bit alone; the first random run continues from here past a twist.
    load_seed(HIGH_BIT);
    send_draw(DRAW_REQ);
    send_draw(DRAW_REQ);

    // Random runs: reseed now and then, mostly requests with some dropped ones.
    // Count every item sent, dropped ones included, and stop at the limit.
    drawn = 0;
    phase = 0;
    while (drawn < RANDOM_DRAWS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (phase != 0 && $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0:       seed = '0;
          1:       seed = '1;
          2:       seed = SEED_DEFAULT;
          default: seed = $urandom();
        endcase
        load_seed(seed);
      end
      run_len = (phase == 0) ? FIRST_RUN : $urandom_range(40, 400);
      for (i = 0; i < run_len && drawn < RANDOM_DRAWS; i++) begin
        if (phase == 0 && i == run_len / 2) begin
          drain();
        end
        if ($urandom_range(0, 9) == 0) begin
          send_draw(DRAW_NONE);
        end else begin
          send_draw(DRAW_REQ);
        end
        drawn++;
      end
      phase++;
    end
    quiet = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mtrg_pkg.sv
rtl/core/mtrg_ifs.sv
rtl/core/mt19937_random_generator_top.sv
rtl/core/mtrg_checker.sv
dv/mtrg_stream_checker.sv
dv/tb.sv
